[hw/rtl/rolling_hash_string_search_core_macros.svh]
// Assertion macros for the rolling hash search core.
// They expect clk and rst_n in the scope of use.
`ifndef ROLLING_HASH_STRING_SEARCH_CORE_MACROS_SVH
`define ROLLING_HASH_STRING_SEARCH_CORE_MACROS_SVH

// same-cycle implication
`define RHS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhs same-cycle check failed");

// next-cycle implication
`define RHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhs next-cycle check failed");

`endif

[hw/rtl/rhs_pkg.sv]
package rhs_pkg;

  localparam int MODE_W = 2;
  localparam int BYTE_W = 8;
  localparam int HASH_W = 32;
  localparam int POS_W  = 16;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam mode_t MODE_CLEAR = 2'd0;
  localparam mode_t MODE_PAT   = 2'd1;
  localparam mode_t MODE_TEXT  = 2'd2;

  typedef struct packed {
    logic clear_all;
    logic pat_add;
    logic txt_start;
    logic txt_mul;
    logic txt_hash;
    logic ver_start;
    logic ver_read;
    logic ver_step;
    logic ver_hit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic text_zero;
    logic pat_full;
    logic hash_hit;
    logic ver_eq;
    logic ver_last;
    logic last;
  } sts_t;

endpackage

[hw/rtl/rhs_in_if.sv]
interface rhs_in_if;
  logic               valid;
  logic               ready;
  rhs_pkg::mode_t     mode;
  rhs_pkg::byte_t     data_byte;
  logic               last;

  modport source (output valid, output mode, output data_byte, output last, input ready);
  modport sink   (input valid, input mode, input data_byte, input last, output ready);
endinterface

[hw/rtl/rhs_out_if.sv]
interface rhs_out_if;
  logic          valid;
  logic          ready;
  logic          found;
  rhs_pkg::pos_t match_position;

  modport source (output valid, output found, output match_position, input ready);
  modport sink   (input valid, input found, input match_position, output ready);
endinterface

[hw/rtl/rhs_ctrl.sv]
module rhs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  rhs_pkg::mode_t in_mode,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rhs_pkg::cmd_t  cmd,
  input  rhs_pkg::sts_t  sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TXT1 = 3'd1;
  localparam logic [2:0] S_TXT2 = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_VRD  = 3'd4;
  localparam logic [2:0] S_VCMP = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            rhs_pkg::MODE_CLEAR: cmd.clear_all = 1'b1;
            rhs_pkg::MODE_PAT: begin
              if (sts.text_zero && !sts.pat_full) cmd.pat_add = 1'b1;
            end
            rhs_pkg::MODE_TEXT: begin
              cmd.txt_start = 1'b1;
              state_nxt     = S_TXT1;
            end
            default: ;
          endcase
        end
      end
      S_TXT1: begin
        cmd.txt_mul = 1'b1;
        state_nxt   = S_TXT2;
      end
      S_TXT2: begin
        cmd.txt_hash = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        if (sts.hash_hit) begin
          cmd.ver_start = 1'b1;
          state_nxt     = S_VRD;
        end else if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_VRD: begin
        cmd.ver_read = 1'b1;
        state_nxt    = S_VCMP;
      end
      S_VCMP: begin
        if (!sts.ver_eq) begin
          state_nxt = S_FIN;
        end else if (sts.ver_last) begin
          cmd.ver_hit = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.ver_step = 1'b1;
          state_nxt    = S_VRD;
        end
      end
      S_FIN: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/rhs_dp.sv]
module rhs_dp #(
  parameter int              PATTERN_MAX = 128,
  parameter longint unsigned TEXT_MAX    = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rhs_pkg::byte_t in_byte,
  input  logic           in_last,
  input  rhs_pkg::cmd_t  cmd,
  output rhs_pkg::sts_t  sts,
  output logic           out_found,
  output rhs_pkg::pos_t  out_pos
);

  localparam int PCW = $clog2(PATTERN_MAX + 1);
  localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int TCW = $clog2(TEXT_MAX + 1);
  localparam int CW0 = (TCW > PCW) ? TCW : PCW;
  localparam int CW  = ((CW0 > rhs_pkg::POS_W) ? CW0 : rhs_pkg::POS_W) + 1;

  function automatic logic [rhs_pkg::HASH_W-1:0] mul10(input logic [rhs_pkg::HASH_W-1:0] x);
    return (x << 3) + (x << 1);
  endfunction

  rhs_pkg::byte_t pat_mem [PATTERN_MAX];
  rhs_pkg::byte_t win_mem [PATTERN_MAX];

  // search and pattern state
  logic [PCW-1:0]             pcount_r;
  logic [rhs_pkg::HASH_W-1:0] phash_r, shift_r, whash_r;
  logic [TCW-1:0]             tcount_r;
  logic                       seen_r;
  rhs_pkg::pos_t              first_r;
  logic [PAW-1:0]             head_r;

  // per-item working registers
  rhs_pkg::byte_t             byte_r, win_rd_r, pat_rd_r;
  logic                       last_r;
  logic [TCW-1:0]             before_r;
  logic [rhs_pkg::HASH_W-1:0] prod_r;
  logic [PAW-1:0]             k_r, p_r;
  logic                       out_found_r;
  rhs_pkg::pos_t              out_pos_r;

  logic [CW-1:0]              m_x, before_x, pos_x;
  logic                       pat_empty, roll, full;
  logic [PAW-1:0]             head_adv, p_adv, win_rd_addr, win_wr_addr;
  logic [rhs_pkg::HASH_W-1:0] hash_base;
  rhs_pkg::pos_t              pos16;

  assign m_x       = CW'(pcount_r);
  assign before_x  = CW'(before_r);
  assign pat_empty = (pcount_r == '0);
  assign roll      = (before_x >= m_x);
  assign full      = (before_x + CW'(1) >= m_x);
  assign head_adv  = (CW'(head_r) == m_x - CW'(1)) ? '0 : head_r + PAW'(1);
  assign p_adv     = (CW'(p_r) == m_x - CW'(1)) ? '0 : p_r + PAW'(1);
  assign win_rd_addr = cmd.ver_read ? p_r : head_r;
  assign win_wr_addr = roll ? head_r : before_r[PAW-1:0];
  assign hash_base = roll ? (whash_r - prod_r) : whash_r;

  assign pos_x = (before_x >= CW'(TEXT_MAX)) ? CW'(TEXT_MAX - 1)
                                             : before_x + CW'(1) - m_x;
  assign pos16 = (pos_x > CW'(16'hFFFF)) ? 16'hFFFF : pos_x[rhs_pkg::POS_W-1:0];

  assign sts.text_zero = (tcount_r == '0);
  assign sts.pat_full  = (pcount_r == PCW'(PATTERN_MAX));
  assign sts.hash_hit  = !seen_r && !pat_empty && full && (whash_r == phash_r);
  assign sts.ver_eq    = (win_rd_r == pat_rd_r);
  assign sts.ver_last  = (CW'(k_r) == m_x - CW'(1));
  assign sts.last      = last_r;

  assign out_found = out_found_r;
  assign out_pos   = out_pos_r;

  always_ff @(posedge clk) begin
    if (cmd.pat_add) pat_mem[pcount_r[PAW-1:0]] <= in_byte;
    if (cmd.ver_read) pat_rd_r <= pat_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.txt_mul && !pat_empty) win_mem[win_wr_addr] <= byte_r;
    if (cmd.txt_start || cmd.ver_read) win_rd_r <= win_mem[win_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= '0;
      phash_r  <= '0;
      shift_r  <= rhs_pkg::HASH_W'(1);
      tcount_r <= '0;
      whash_r  <= '0;
      seen_r   <= 1'b0;
      first_r  <= '0;
      head_r   <= '0;
    end else if (cmd.clear_all) begin
      pcount_r <= '0;
      phash_r  <= '0;
      shift_r  <= rhs_pkg::HASH_W'(1);
      tcount_r <= '0;
      whash_r  <= '0;
      seen_r   <= 1'b0;
      first_r  <= '0;
      head_r   <= '0;
    end else if (cmd.emit) begin
      tcount_r <= '0;
      whash_r  <= '0;
      seen_r   <= 1'b0;
      first_r  <= '0;
      head_r   <= '0;
    end else begin
      if (cmd.pat_add) begin
        if (!pat_empty) shift_r <= mul10(shift_r);
        phash_r  <= mul10(phash_r) + rhs_pkg::HASH_W'(in_byte);
        pcount_r <= pcount_r + PCW'(1);
      end
      if (cmd.txt_start && (tcount_r < TCW'(TEXT_MAX))) tcount_r <= tcount_r + TCW'(1);
      if (cmd.txt_mul && !pat_empty && roll) head_r <= head_adv;
      if (cmd.txt_hash) begin
        if (pat_empty) begin
          if (!seen_r) begin
            seen_r  <= 1'b1;
            first_r <= '0;
          end
        end else begin
          whash_r <= mul10(hash_base) + rhs_pkg::HASH_W'(byte_r);
        end
      end
      if (cmd.ver_hit) begin
        seen_r  <= 1'b1;
        first_r <= pos16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.txt_start) begin
      byte_r   <= in_byte;
      last_r   <= in_last;
      before_r <= tcount_r;
    end
    if (cmd.txt_mul) prod_r <= rhs_pkg::HASH_W'(win_rd_r) * shift_r;
    if (cmd.ver_start) begin
      k_r <= '0;
      p_r <= head_r;
    end else if (cmd.ver_step) begin
      k_r <= k_r + PAW'(1);
      p_r <= p_adv;
    end
    if (cmd.emit) begin
      out_found_r <= seen_r;
      out_pos_r   <= seen_r ? first_r : '0;
    end
  end

endmodule

[hw/rtl/rolling_hash_string_search_core.sv]
// Clear and pattern items are done in IDLE; a text item passes IDLE, TXT1, TXT2 and CHK,
// plus VRD and VCMP per byte compared and FIN when the window hash hits (serial check).
// No item is taken until a text item is through; a result waits in an output register so
// the next text can start, but a last item waits in FIN while that register is full.
// Reset (rst_n low, synchronous) empties pattern and search, not the pattern/window RAMs.
`include "rolling_hash_string_search_core_macros.svh"

module rolling_hash_string_search_core #(
  parameter int              PATTERN_MAX = 128,
  parameter longint unsigned TEXT_MAX    = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  rhs_in_if.sink            in_ch,
  rhs_out_if.source         out_ch
);

  rhs_pkg::cmd_t cmd;
  rhs_pkg::sts_t sts;

  rhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rhs_dp #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_ch.data_byte),
    .in_last   (in_ch.last),
    .cmd       (cmd),
    .sts       (sts),
    .out_found (out_ch.found),
    .out_pos   (out_ch.match_position)
  );

  `RHS_ASSERT_NEXT(a_text_busy, in_ch.valid && in_ch.ready && in_ch.mode == rhs_pkg::MODE_TEXT, !in_ch.ready)
  `RHS_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd))
  `RHS_ASSERT_NOW(a_miss_pos_zero, out_ch.valid && !out_ch.found, out_ch.match_position == '0)

endmodule

[tb/tb_rolling_hash_string_search_core.sv]
`timescale 1ns / 100ps

module tb_rolling_hash_string_search_core;

  localparam int unsigned PAT_DEPTH = 128;
  localparam int unsigned TEXT_CAP = 65536;
  localparam logic [31:0] HASH_BASE = 32'd10;
  localparam rhs_pkg::mode_t MODE_RSVD = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int LONG_TEXT_LEN = 90;

  typedef struct packed {
    logic found;
    rhs_pkg::pos_t match_position;
  } search_result_t;

  logic clk;
  logic rst_n;

  rhs_in_if in_if ();
  rhs_out_if out_if ();

  rolling_hash_string_search_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // search state mirror
  rhs_pkg::byte_t pat_mem [PAT_DEPTH];
  rhs_pkg::byte_t win_mem [PAT_DEPTH];
  int unsigned pat_len;
  logic [31:0] pat_hash;
  logic [31:0] shift_pow;
  logic [31:0] win_hash;
  int unsigned txt_cnt;
  bit hit_seen;
  rhs_pkg::pos_t hit_pos;

  search_result_t expected_q[$];
  int err_count = 0;
  int items_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_text_state();
    win_hash = '0;
    txt_cnt = 0;
    hit_seen = 1'b0;
    hit_pos = '0;
  endfunction

  function automatic void clear_all_state();
    pat_len = 0;
    pat_hash = '0;
    shift_pow = 32'd1;
    clear_text_state();
  endfunction

  function automatic void predict_search(input rhs_pkg::mode_t m, input rhs_pkg::byte_t b,
                                         input logic l);
    int unsigned prior;
    int unsigned k;
    int unsigned pos;
    logic [31:0] oldest;
    bit same;
    search_result_t r;
    case (m)
      rhs_pkg::MODE_CLEAR: begin
        clear_all_state();
      end
      rhs_pkg::MODE_PAT: begin
        if (txt_cnt == 0 && pat_len < PAT_DEPTH) begin
          if (pat_len > 0) shift_pow = shift_pow * HASH_BASE;
          pat_mem[pat_len] = b;
          pat_hash = pat_hash * HASH_BASE + {24'd0, b};
          pat_len++;
        end
      end
      rhs_pkg::MODE_TEXT: begin
        prior = txt_cnt;
        if (txt_cnt < TEXT_CAP) txt_cnt++;
        if (pat_len == 0) begin
          if (!hit_seen) begin
            hit_seen = 1'b1;
            hit_pos = '0;
          end
        end else begin
          if (prior >= pat_len) begin
            oldest = {24'd0, win_mem[0]};
            for (k = 0; k + 1 < pat_len; k++) win_mem[k] = win_mem[k+1];
            win_mem[pat_len-1] = b;
            win_hash = (win_hash - oldest * shift_pow) * HASH_BASE + {24'd0, b};
          end else begin
            win_mem[prior] = b;
            win_hash = win_hash * HASH_BASE + {24'd0, b};
          end
          if (!hit_seen && prior + 1 >= pat_len && win_hash == pat_hash) begin
            same = 1'b1;
            for (k = 0; k < pat_len; k++) if (win_mem[k] != pat_mem[k]) same = 1'b0;
            if (same) begin
              pos = (prior >= TEXT_CAP) ? TEXT_CAP - 1 : prior + 1 - pat_len;
              if (pos > 65535) pos = 65535;
              hit_seen = 1'b1;
              hit_pos = pos[15:0];
            end
          end
        end
        if (l) begin
          r.found = hit_seen;
          r.match_position = hit_seen ? hit_pos : '0;
          expected_q.push_back(r);
          clear_text_state();
        end
      end
      default: begin
      end
    endcase
  endfunction

  // sender: called right after a rising edge, returns right after the item is taken
  task automatic send_item(input rhs_pkg::mode_t m, input rhs_pkg::byte_t b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= m;
    in_if.data_byte <= b;
    in_if.last <= l;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_search(m, b, l);
    items_sent++;
  endtask

  task automatic send_pattern(input rhs_pkg::byte_t pat[$]);
    foreach (pat[k]) send_item(rhs_pkg::MODE_PAT, pat[k], 1'b0);
  endtask

  task automatic send_text(input rhs_pkg::byte_t txt[$]);
    foreach (txt[k]) send_item(rhs_pkg::MODE_TEXT, txt[k], k == txt.size() - 1);
  endtask

  function automatic rhs_pkg::byte_t pick_byte(input bit wide, input rhs_pkg::byte_t base);
    rhs_pkg::byte_t v;
    if (wide) v = rhs_pkg::byte_t'($urandom);
    else v = base + rhs_pkg::byte_t'($urandom_range(2));
    return v;
  endfunction

  // receiver and result check
  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: found %0d match_position %0d",
               out_if.found, out_if.match_position);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_if.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_if.found);
          err_count++;
        end
        if (out_if.match_position !== want.match_position) begin
          $error("match_position: expected %0d, actual %0d",
                 want.match_position, out_if.match_position);
          err_count++;
        end
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic test_empty_pattern();
    send_item(rhs_pkg::MODE_CLEAR, 8'h00, 1'b0);
    send_text('{8'h00});
    send_text('{8'hFF, 8'h12});
  endtask

  task automatic test_single_match();
    send_item(rhs_pkg::MODE_CLEAR, 8'hFF, 1'b0);
    send_pattern('{8'hFF, 8'h00});
    send_text('{8'h33, 8'hFF, 8'h00, 8'hFF});
    send_text('{8'h00, 8'hFF, 8'hFF});
  endtask

  // equal window hash with different bytes
  task automatic test_hash_collision();
    send_item(rhs_pkg::MODE_CLEAR, 8'h00, 1'b0);
    send_pattern('{8'h01, 8'h00});
    send_text('{8'h00, 8'h0A});
    send_text('{8'h00, 8'h0A, 8'h01, 8'h00});
  endtask

  task automatic test_short_text();
    send_item(rhs_pkg::MODE_CLEAR, 8'h00, 1'b0);
    send_pattern('{8'h01, 8'h02, 8'h03});
    send_text('{8'h01, 8'h02});
  endtask

  task automatic test_ignored_items();
    send_item(rhs_pkg::MODE_CLEAR, 8'hFF, 1'b1);
    send_item(MODE_RSVD, 8'hFF, 1'b1);
    send_item(rhs_pkg::MODE_PAT, 8'hA5, 1'b1);
    send_item(rhs_pkg::MODE_TEXT, 8'h00, 1'b0);
    send_item(rhs_pkg::MODE_PAT, 8'hA5, 1'b0);
    send_item(MODE_RSVD, 8'h00, 1'b1);
    send_item(rhs_pkg::MODE_TEXT, 8'hA5, 1'b1);
    // pattern grows again once the text has ended
    send_item(rhs_pkg::MODE_PAT, 8'h5A, 1'b0);
    send_text('{8'hA5, 8'h5A});
  endtask

  task automatic test_pattern_overflow();
    rhs_pkg::byte_t pat[$];
    rhs_pkg::byte_t txt[$];
    int k;
    send_item(rhs_pkg::MODE_CLEAR, 8'h00, 1'b0);
    for (k = 0; k < PAT_DEPTH + 2; k++) pat.push_back(rhs_pkg::byte_t'($urandom));
    send_pattern(pat);
    for (k = 0; k < PAT_DEPTH; k++) txt.push_back(pat_mem[k]);
    send_text(txt);
  endtask

  task automatic test_long_text();
    int k;
    send_item(rhs_pkg::MODE_CLEAR, 8'h00, 1'b0);
    send_pattern('{8'h07, 8'h08, 8'h09});
    for (k = 0; k < LONG_TEXT_LEN; k++)
      send_item(rhs_pkg::MODE_TEXT, rhs_pkg::byte_t'($urandom_range(100, 255)), 1'b0);
    send_item(rhs_pkg::MODE_TEXT, 8'h07, 1'b0);
    send_item(rhs_pkg::MODE_TEXT, 8'h08, 1'b0);
    send_item(rhs_pkg::MODE_TEXT, 8'h09, 1'b1);
  endtask

  task automatic test_output_backpressure();
    int k;
    send_item(rhs_pkg::MODE_CLEAR, 8'h00, 1'b0);
    hold_req++;
    for (k = 0; k < 8; k++) send_item(rhs_pkg::MODE_TEXT, rhs_pkg::byte_t'($urandom), 1'b1);
    send_pattern('{8'h44});
    for (k = 0; k < 6; k++) send_text('{8'h44, 8'h43 + rhs_pkg::byte_t'(k % 2)});
  endtask

  task automatic test_random_texts(input int n_items);
    int start;
    int plen;
    int tlen;
    int ins;
    int k;
    bit wide;
    rhs_pkg::byte_t base;
    rhs_pkg::byte_t txt[$];
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(2))
          0: send_item(MODE_RSVD, rhs_pkg::byte_t'($urandom), 1'($urandom));
          1: send_item(rhs_pkg::MODE_PAT, rhs_pkg::byte_t'($urandom), 1'($urandom));
          default: send_item(rhs_pkg::MODE_CLEAR, rhs_pkg::byte_t'($urandom), 1'($urandom));
        endcase
      end else begin
        if (pat_len > 16 || $urandom_range(99) < 60)
          send_item(rhs_pkg::MODE_CLEAR, rhs_pkg::byte_t'($urandom), 1'($urandom));
        wide = ($urandom_range(2) == 0);
        base = rhs_pkg::byte_t'($urandom);
        plen = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        if ($urandom_range(19) == 0) plen = $urandom_range(7, 20);
        for (k = 0; k < plen; k++)
          send_item(rhs_pkg::MODE_PAT, pick_byte(wide, base), 1'($urandom));
        tlen = ((pat_len == 0) ? 1 : pat_len) + $urandom_range(0, 20);
        if ($urandom_range(4) == 0) tlen = tlen - $urandom_range(0, pat_len);
        if (tlen < 1) tlen = 1;
        txt.delete();
        for (k = 0; k < tlen; k++) txt.push_back(pick_byte(wide, base));
        if (pat_len > 0 && tlen >= pat_len && $urandom_range(99) < 60) begin
          ins = $urandom_range(0, tlen - pat_len);
          for (k = 0; k < pat_len; k++) txt[ins+k] = pat_mem[k];
        end
        foreach (txt[j]) begin
          if (j > 0 && $urandom_range(99) < 4)
            send_item(($urandom_range(1) == 0) ? MODE_RSVD : rhs_pkg::MODE_PAT,
                      rhs_pkg::byte_t'($urandom), 1'($urandom));
          send_item(rhs_pkg::MODE_TEXT, txt[j], j == tlen - 1);
        end
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = rhs_pkg::MODE_CLEAR;
    in_if.data_byte = '0;
    in_if.last = 1'b0;
    rst_n = 1'b0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clear_all_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pattern();
    send_idle_pct = 58;
    test_single_match();
    recv_stall_pct = 58;
    test_hash_collision();
    send_idle_pct = 0;
    test_short_text();
    send_idle_pct = 22;
    recv_stall_pct = 22;
    test_ignored_items();
    test_pattern_overflow();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_long_text();
    recv_stall_pct = 22;
    test_output_backpressure();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_texts(150);
    send_idle_pct = 58;
    test_random_texts(150);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    test_random_texts(150);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    test_random_texts(150);

    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rhs_pkg.sv
hw/rtl/rhs_in_if.sv
hw/rtl/rhs_out_if.sv
hw/rtl/rhs_ctrl.sv
hw/rtl/rhs_dp.sv
hw/rtl/rolling_hash_string_search_core.sv
tb/tb_rolling_hash_string_search_core.sv
